/* hw/rtl/pna_pkg.sv */
// pna_pkg: shared widths, register codes, reset values and item types
// for the patchify address and normalize core
// no dependencies
package pna_pkg;

    // field widths
    localparam int CoordW   = 13;
    localparam int LevelW   = 8;
    localparam int GridW    = 9;
    localparam int ScaleW   = 24;
    localparam int OffsetW  = 24;
    localparam int ValueW   = 26;
    localparam int NumW     = 18;
    localparam int OffOutW  = 8;
    localparam int AddrW    = 28;
    localparam int ProdW    = ScaleW + LevelW;

    // stream payload widths, packed low field first, padded to bytes
    localparam int InFieldsW  = 2 * CoordW + 3 * LevelW;
    localparam int InDataW    = ((InFieldsW + 7) / 8) * 8;
    localparam int OutFieldsW = NumW + OffOutW + AddrW + 3 * ValueW;
    localparam int OutDataW   = ((OutFieldsW + 7) / 8) * 8;

    // configuration port
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 24;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_GRID_COLUMNS = 2'd0,
        CFG_NORM_SCALE   = 2'd1,
        CFG_NORM_OFFSET  = 2'd2
    } t_cfg_reg;

    localparam logic [GridW-1:0]   RstGridColumns = GridW'(1);
    localparam logic [ScaleW-1:0]  RstNormScale   = ScaleW'(131586);
    localparam logic [OffsetW-1:0] RstNormOffset  = OffsetW'(-65536);

    // parameter defaults
    localparam int DefPatch   = 14;
    localparam int DefMaxGrid = 511;

    // decoupling queue depth between front and back
    localparam int QueueDepth = 4;

    typedef struct packed {
        logic [GridW-1:0]   grid_columns;
        logic [ScaleW-1:0]  norm_scale;
        logic [OffsetW-1:0] norm_offset;
    } t_cfg;

    // classified item handed from front to back
    typedef struct packed {
        logic [CoordW-1:0] gx;
        logic [CoordW-1:0] gy;
        logic [CoordW-1:0] col;
        logic [CoordW-1:0] row;
        logic [LevelW-1:0] red;
        logic [LevelW-1:0] green;
        logic [LevelW-1:0] blue;
    } t_item;

endpackage

/* hw/rtl/pna_front.sv */
// pna_front: accepts pixels and splits coordinates into patch grid position
// depends on pna_pkg
module pna_front #(
    parameter int PATCH = pna_pkg::DefPatch
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [pna_pkg::InDataW-1:0]  i_data,
    output logic                         o_valid,
    input  logic                         i_ready,
    output pna_pkg::t_item               o_item
);
    localparam int CoordW   = pna_pkg::CoordW;
    localparam int LevelW   = pna_pkg::LevelW;
    // exact quotient of any coordinate by reciprocal multiply
    localparam int DivShift = CoordW + $clog2(PATCH);
    localparam int RecipW   = DivShift + 1;
    localparam int Recip    = ((1 << DivShift) + PATCH - 1) / PATCH;
    localparam int MulW     = CoordW + RecipW;

    logic                   r_valid;
    pna_pkg::t_item         r_item;
    pna_pkg::t_item         n_item;
    logic [CoordW-1:0]      col;
    logic [CoordW-1:0]      row;
    logic [MulW-1:0]        col_mul;
    logic [MulW-1:0]        row_mul;

    assign col = i_data[CoordW-1:0];
    assign row = i_data[2*CoordW-1:CoordW];

    assign col_mul = MulW'(col) * MulW'(Recip);
    assign row_mul = MulW'(row) * MulW'(Recip);

    always_comb begin
        n_item.gx    = col_mul[DivShift +: CoordW];
        n_item.gy    = row_mul[DivShift +: CoordW];
        n_item.col   = col;
        n_item.row   = row;
        n_item.red   = i_data[2*CoordW +: LevelW];
        n_item.green = i_data[2*CoordW+LevelW +: LevelW];
        n_item.blue  = i_data[2*CoordW+2*LevelW +: LevelW];
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

/* hw/rtl/pna_queue.sv */
// pna_queue: short fifo that decouples the front from the back
// depends on pna_pkg
module pna_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  pna_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output pna_pkg::t_item o_item
);
    localparam int Depth  = pna_pkg::QueueDepth;
    localparam int PtrW   = $clog2(Depth);
    localparam int CountW = $clog2(Depth + 1);

    pna_pkg::t_item      r_mem [Depth];
    logic [PtrW-1:0]     r_wr_ptr;
    logic [PtrW-1:0]     r_rd_ptr;
    logic [CountW-1:0]   r_count;
    logic [CountW-1:0]   n_count;
    logic                push;
    logic                pop;

    assign o_ready = (r_count != CountW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + CountW'(1);
        end else if (pop && !push) begin
            n_count = r_count - CountW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + PtrW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // fill count never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountW'(Depth))
        else $error("queue count above depth");

    // count goes up by one on a push without a pop
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + CountW'(1)))
        else $error("queue count missed a push");

    // pointers stay consistent with the fill count
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != CountW'(Depth)) |-> (PtrW'(r_wr_ptr - r_rd_ptr) == r_count[PtrW-1:0]))
        else $error("queue pointers out of step with count");

endmodule

/* hw/rtl/pna_back.sv */
// pna_back: two-stage pipeline forming patch number, offset, address and
// normalized channels, with the output register; depends on pna_pkg
module pna_back #(
    parameter int PATCH    = pna_pkg::DefPatch,
    parameter int MAX_GRID = pna_pkg::DefMaxGrid
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pna_pkg::t_cfg                 i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  pna_pkg::t_item                i_item,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [pna_pkg::OutDataW-1:0]  o_data
);
    localparam int CoordW    = pna_pkg::CoordW;
    localparam int GridW     = pna_pkg::GridW;
    localparam int ProdW     = pna_pkg::ProdW;
    localparam int ValueW    = pna_pkg::ValueW;
    localparam int OffsetW   = pna_pkg::OffsetW;
    localparam int NumW      = pna_pkg::NumW;
    localparam int OffOutW   = pna_pkg::OffOutW;
    localparam int AddrW     = pna_pkg::AddrW;
    localparam int OutDataW  = pna_pkg::OutDataW;
    localparam int PadW      = OutDataW - pna_pkg::OutFieldsW;
    localparam int PxW       = (PATCH > 1) ? $clog2(PATCH) : 1;
    localparam int OffW      = (PATCH > 1) ? $clog2(PATCH * PATCH) : 1;
    localparam int OffExtW   = (OffW > OffOutW) ? OffW : OffOutW;
    localparam int NumFullW  = CoordW + GridW + 1;
    localparam int Stride    = 3 * PATCH * PATCH;
    localparam int StrideW   = $clog2(Stride + 1);
    localparam int AddrSumW  = NumFullW + StrideW;
    localparam int AddrFullW = (AddrSumW > AddrW) ? AddrSumW : AddrW;
    localparam int RoundW    = ProdW + 1;

    // stage a: positions inside the patch, patch number, channel products
    logic                   r_a_valid;
    logic [PxW-1:0]         r_a_px;
    logic [PxW-1:0]         r_a_py;
    logic [NumFullW-1:0]    r_a_num;
    logic [ProdW-1:0]       r_a_prod [3];
    // stage b: output register
    logic                   r_b_valid;
    logic [OutDataW-1:0]    r_b_data;

    logic                   a_ready;
    logic                   b_ready;
    logic [GridW-1:0]       grid_eff;
    logic [CoordW-1:0]      px_full;
    logic [CoordW-1:0]      py_full;
    logic [NumFullW-1:0]    n_a_num;
    logic [OffW-1:0]        off;
    logic [OffExtW-1:0]     off_ext;
    logic [AddrFullW-1:0]   addr_full;
    logic [ValueW-1:0]      value [3];
    logic [OutDataW-1:0]    n_b_data;

    // round half up from 24 to 16 fraction bits, then add the offset
    function automatic logic [ValueW-1:0] norm_value(
        input logic [ProdW-1:0]   prod,
        input logic [OffsetW-1:0] offset
    );
        logic [RoundW-1:0] rounded;
        rounded = (RoundW'(prod) + RoundW'(128)) >> 8;
        return ValueW'(rounded) + {{(ValueW-OffsetW){offset[OffsetW-1]}}, offset};
    endfunction

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;
    assign o_valid = r_b_valid;
    assign o_data  = r_b_data;

    assign grid_eff = (i_cfg.grid_columns > GridW'(MAX_GRID)) ? GridW'(MAX_GRID)
                                                              : i_cfg.grid_columns;
    assign px_full  = i_item.col - CoordW'(i_item.gx * CoordW'(PATCH));
    assign py_full  = i_item.row - CoordW'(i_item.gy * CoordW'(PATCH));
    assign n_a_num  = NumFullW'(i_item.gy) * NumFullW'(grid_eff) + NumFullW'(i_item.gx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_px      <= px_full[PxW-1:0];
            r_a_py      <= py_full[PxW-1:0];
            r_a_num     <= n_a_num;
            r_a_prod[0] <= ProdW'(i_cfg.norm_scale) * ProdW'(i_item.red);
            r_a_prod[1] <= ProdW'(i_cfg.norm_scale) * ProdW'(i_item.green);
            r_a_prod[2] <= ProdW'(i_cfg.norm_scale) * ProdW'(i_item.blue);
        end
    end

    // stage b: offset, flat address and channel values
    assign off       = OffW'(r_a_py * OffW'(PATCH)) + OffW'(r_a_px);
    assign off_ext   = OffExtW'(off);
    assign addr_full = AddrFullW'(r_a_num) * AddrFullW'(Stride) + AddrFullW'(off);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            value[c] = norm_value(r_a_prod[c], i_cfg.norm_offset);
        end
        n_b_data = {{PadW{1'b0}}, value[2], value[1], value[0],
                    addr_full[AddrW-1:0], off_ext[OffOutW-1:0], r_a_num[NumW-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_valid) begin
            r_b_data <= n_b_data;
        end
    end

    // a stalled stage a keeps its item
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !b_ready) |=> r_a_valid)
        else $error("stage a dropped a stalled item");

    a_hold_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !b_ready) |=> $stable(r_a_num))
        else $error("stage a changed a stalled item");

    // a new result only comes out of a filled stage a
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_b_valid) |-> $past(r_a_valid))
        else $error("result without a source item");

endmodule

/* hw/rtl/patchify_normalize_address_core.sv */
// patchify_normalize_address_core: top level with configuration registers,
// front, queue and back; depends on pna_pkg, pna_front, pna_queue, pna_back
//
// Takes one pixel (column, row, red, green, blue) per cycle unless stalled, and
// returns, per pixel, the row-major patch number over a grid of grid_columns
// patches of side PATCH, the offset inside the patch, the flat address of the
// red element in patch-major, channel-planar order (green and blue follow at
// strides of PATCH*PATCH), and each channel normalized as norm_scale*u +
// norm_offset with the product rounded half up to 16 fraction bits. Sustained
// rate is one item per clock while the receiver stays ready. Each item passes
// the front register, a queue entry, back stage a and the output register. The
// four-entry queue lets the front keep accepting while the output is held,
// until the queue is full. Configuration must be written only while the block
// holds no item; the block itself does not enforce this. A grid_columns value
// above MAX_GRID acts as MAX_GRID.
module patchify_normalize_address_core #(
    parameter int PATCH    = pna_pkg::DefPatch,
    parameter int MAX_GRID = pna_pkg::DefMaxGrid
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [pna_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [pna_pkg::CfgDataW-1:0]   i_cfg_data,
    // pixel input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // pixel_column, pixel_row, red_level, green_level, blue_level, zero pad
    input  logic [pna_pkg::InDataW-1:0]    s_axis_tdata,
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // patch_number, offset_in_patch, red_address, red_value, green_value,
    // blue_value, zero pad
    output logic [pna_pkg::OutDataW-1:0]   m_axis_tdata
);
    localparam int GridW   = pna_pkg::GridW;
    localparam int ScaleW  = pna_pkg::ScaleW;
    localparam int OffsetW = pna_pkg::OffsetW;

    // configuration registers
    logic [GridW-1:0]    r_grid_columns;
    logic [ScaleW-1:0]   r_norm_scale;
    logic [OffsetW-1:0]  r_norm_offset;
    pna_pkg::t_cfg       cfg;

    // front to queue, queue to back
    logic                front_valid;
    logic                front_ready;
    pna_pkg::t_item      front_item;
    logic                queue_valid;
    logic                queue_ready;
    pna_pkg::t_item      queue_item;

    // writes to an unknown index fall through and are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns <= pna_pkg::RstGridColumns;
            r_norm_scale   <= pna_pkg::RstNormScale;
            r_norm_offset  <= pna_pkg::RstNormOffset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pna_pkg::CFG_GRID_COLUMNS: begin
                    r_grid_columns <= i_cfg_data[GridW-1:0];
                end
                pna_pkg::CFG_NORM_SCALE: begin
                    r_norm_scale <= i_cfg_data[ScaleW-1:0];
                end
                pna_pkg::CFG_NORM_OFFSET: begin
                    r_norm_offset <= i_cfg_data[OffsetW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.grid_columns = r_grid_columns;
        cfg.norm_scale   = r_norm_scale;
        cfg.norm_offset  = r_norm_offset;
    end

    // front: accept pixel, divide coordinates by the patch side
    pna_front #(
        .PATCH (PATCH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (front_valid),
        .i_ready (front_ready),
        .o_item  (front_item)
    );

    // queue: lets front and back stall independently
    pna_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_item  (front_item),
        .o_valid (queue_valid),
        .i_ready (queue_ready),
        .o_item  (queue_item)
    );

    // back: patch number, address and normalize, output register
    pna_back #(
        .PATCH    (PATCH),
        .MAX_GRID (MAX_GRID)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (queue_valid),
        .o_ready (queue_ready),
        .i_item  (queue_item),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

/* sim/pna_pixel_checker.sv */
`timescale 1ns / 100ps
// pna_pixel_checker: watches the config port and both pixel streams, predicts
// each result and compares it field by field; depends on pna_pkg only
module pna_pixel_checker #(
    parameter int PATCH    = pna_pkg::DefPatch,
    parameter int MAX_GRID = pna_pkg::DefMaxGrid
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pna_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [pna_pkg::CfgDataW-1:0]   i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    // pixel_column, pixel_row, red_level, green_level, blue_level, zero pad
    input  logic [pna_pkg::InDataW-1:0]    i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    // patch_number, offset_in_patch, red_address, red_value, green_value,
    // blue_value, zero pad
    input  logic [pna_pkg::OutDataW-1:0]   i_out_data,
    output int                             o_errors,
    output int                             o_pending
);
    localparam int CoordW     = pna_pkg::CoordW;
    localparam int LevelW     = pna_pkg::LevelW;
    localparam int GridW      = pna_pkg::GridW;
    localparam int ScaleW     = pna_pkg::ScaleW;
    localparam int OffsetW    = pna_pkg::OffsetW;
    localparam int ValueW     = pna_pkg::ValueW;
    localparam int NumW       = pna_pkg::NumW;
    localparam int OffOutW    = pna_pkg::OffOutW;
    localparam int AddrW      = pna_pkg::AddrW;
    localparam int InDataW    = pna_pkg::InDataW;
    localparam int OutFieldsW = pna_pkg::OutFieldsW;

    localparam longint RoundHalf = 128;
    localparam int     FracDrop  = 8;
    localparam int     MaxShown  = 10;

    // first member sits in the top bits, so this matches the tdata layout
    typedef struct packed {
        logic [ValueW-1:0]  blue_value;
        logic [ValueW-1:0]  green_value;
        logic [ValueW-1:0]  red_value;
        logic [AddrW-1:0]   red_address;
        logic [OffOutW-1:0] offset_in_patch;
        logic [NumW-1:0]    patch_number;
    } t_pixel_result;

    logic [GridW-1:0]   grid_columns;
    logic [ScaleW-1:0]  norm_scale;
    logic [OffsetW-1:0] norm_offset;
    t_pixel_result      expected_pixels[$];

    function automatic logic [ValueW-1:0] normalize_level(input logic [LevelW-1:0] u);
        longint prod;
        prod = longint'(norm_scale) * longint'(u);
        return ValueW'(((prod + RoundHalf) >>> FracDrop) + longint'($signed(norm_offset)));
    endfunction

    function automatic t_pixel_result predict_pixel(input logic [InDataW-1:0] data);
        longint col;
        longint row;
        longint width;
        longint num;
        longint off;
        t_pixel_result res;
        col   = data[0 +: CoordW];
        row   = data[CoordW +: CoordW];
        width = (grid_columns > MAX_GRID) ? MAX_GRID : grid_columns;
        num   = (row / PATCH) * width + col / PATCH;
        off   = (row % PATCH) * PATCH + col % PATCH;
        res.patch_number    = NumW'(num);
        res.offset_in_patch = OffOutW'(off);
        res.red_address     = AddrW'(num * 3 * PATCH * PATCH + off);
        res.red_value       = normalize_level(data[2*CoordW +: LevelW]);
        res.green_value     = normalize_level(data[2*CoordW+LevelW +: LevelW]);
        res.blue_value      = normalize_level(data[2*CoordW+2*LevelW +: LevelW]);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_pixel_result got;
        t_pixel_result want;
        if (!i_rst_n) begin
            grid_columns = pna_pkg::RstGridColumns;
            norm_scale   = pna_pkg::RstNormScale;
            norm_offset  = pna_pkg::RstNormOffset;
            o_errors     = 0;
            expected_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (pna_pkg::t_cfg_reg'(i_cfg_index))
                    pna_pkg::CFG_GRID_COLUMNS: grid_columns = i_cfg_data[GridW-1:0];
                    pna_pkg::CFG_NORM_SCALE:   norm_scale   = i_cfg_data[ScaleW-1:0];
                    pna_pkg::CFG_NORM_OFFSET:  norm_offset  = i_cfg_data[OffsetW-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_data[OutFieldsW-1:0];
                if (expected_pixels.size() == 0) begin
                    if (o_errors < MaxShown)
                        $display("unexpected result item %h", got);
                    o_errors = o_errors + 1;
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.patch_number != want.patch_number ||
                            got.offset_in_patch != want.offset_in_patch ||
                            got.red_address != want.red_address ||
                            got.red_value != want.red_value ||
                            got.green_value != want.green_value ||
                            got.blue_value != want.blue_value) begin
                        if (o_errors < MaxShown) begin
                            $display("mismatch exp: num %0d off %0d addr %0d r %h g %h b %h",
                                     want.patch_number, want.offset_in_patch,
                                     want.red_address, want.red_value,
                                     want.green_value, want.blue_value);
                            $display("         got: num %0d off %0d addr %0d r %h g %h b %h",
                                     got.patch_number, got.offset_in_patch,
                                     got.red_address, got.red_value,
                                     got.green_value, got.blue_value);
                        end
                        o_errors = o_errors + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_pixels.push_back(predict_pixel(i_in_data));
        end
        o_pending = expected_pixels.size();
    end

endmodule

/* sim/tb_patchify_normalize_address_core.sv */
`timescale 1ns / 100ps
// tb_patchify_normalize_address_core: pixel stimulus, register writes and
// verdict; depends on pna_pkg, patchify_normalize_address_core, pna_pixel_checker
module tb_patchify_normalize_address_core;
    localparam int CfgIdxW  = pna_pkg::CfgIdxW;
    localparam int CfgDataW = pna_pkg::CfgDataW;
    localparam int InDataW  = pna_pkg::InDataW;
    localparam int OutDataW = pna_pkg::OutDataW;
    localparam int CoordW   = pna_pkg::CoordW;
    localparam int LevelW   = pna_pkg::LevelW;
    localparam int GridW    = pna_pkg::GridW;
    localparam int ScaleW   = pna_pkg::ScaleW;
    localparam int OffsetW  = pna_pkg::OffsetW;
    localparam int MaxGrid  = pna_pkg::DefMaxGrid;

    localparam int Patch       = pna_pkg::DefPatch;
    localparam int MaxCoord    = 7153;
    localparam int PhaseCount  = 8;
    localparam int PhaseItems  = 180;
    // long receiver hold-off, in cycles, so the queue fills and input stalls
    localparam int HoldCycles  = 300;
    // extra wait beyond the pipeline latency
    localparam int DrainCycles = 12;
    localparam int LimitCycles = 800000;
    // index with no register behind it
    localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CfgIdxW-1:0]   i_cfg_index;
    logic [CfgDataW-1:0]  i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [InDataW-1:0]   s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OutDataW-1:0]  m_axis_tdata;

    int          errors;
    int          pending;
    int unsigned cycle_count;
    // stretches without idling on either side
    bit          tx_steady;
    bit          rx_steady;
    // long hold-offs asked by the stimulus and served by the receiver
    int          hold_reqs;
    int          holds_done;

    patchify_normalize_address_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    pna_pixel_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (s_axis_tvalid),
        .i_in_ready (s_axis_tready),
        .i_in_data  (s_axis_tdata),
        .i_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_out_data (m_axis_tdata),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // hard stop in case the pipeline hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LimitCycles) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // idle length: mostly none, often short, now and then long
    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // coordinates: mostly inside the image, some on patch borders, some
    // anywhere in the 13-bit field so pixels also land outside the grid
    function automatic logic [CoordW-1:0] rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return CoordW'($urandom);
        if (r < 25)
            return CoordW'($urandom_range(0, MaxCoord / Patch) * Patch +
                           ($urandom_range(0, 1) ? Patch - 1 : 0));
        return CoordW'($urandom_range(0, MaxCoord));
    endfunction

    function automatic logic [LevelW-1:0] rand_level();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return LevelW'($urandom);
        endcase
    endfunction

    // called right after an accept edge or with the stream idle
    task automatic send_pixel(input logic [CoordW-1:0] col, input logic [CoordW-1:0] row,
                              input logic [LevelW-1:0] red, input logic [LevelW-1:0] green,
                              input logic [LevelW-1:0] blue);
        int gap;
        gap = pick_gap(tx_steady);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = InDataW'({blue, green, red, row, col});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // new settings per phase, the extremes among them; unused upper bits of
    // the grid write carry noise, which the block has to drop
    task automatic random_config();
        logic [GridW-1:0]   grid;
        logic [ScaleW-1:0]  scale;
        logic [OffsetW-1:0] offset;
        case ($urandom_range(0, 5))
            0:       grid = '0;
            1:       grid = GridW'(1);
            2:       grid = GridW'(MaxGrid);
            default: grid = GridW'($urandom_range(1, MaxGrid));
        endcase
        case ($urandom_range(0, 5))
            0:       scale = '0;
            1:       scale = '1;
            2:       scale = pna_pkg::RstNormScale;
            default: scale = ScaleW'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0:       offset = 24'h800000;
            1:       offset = 24'h7fffff;
            2:       offset = pna_pkg::RstNormOffset;
            default: offset = OffsetW'($urandom);
        endcase
        write_reg(pna_pkg::CFG_GRID_COLUMNS, CfgDataW'({15'($urandom), grid}));
        write_reg(pna_pkg::CFG_NORM_SCALE, scale);
        write_reg(pna_pkg::CFG_NORM_OFFSET, offset);
        if ($urandom_range(0, 3) == 0)
            write_reg(CfgUnused, CfgDataW'($urandom));
    endtask

    // receiver: random stalls, steady stretches, and the long hold-off
    initial begin
        int gap_left;
        gap_left      = 0;
        holds_done    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_done != hold_reqs) begin
                m_axis_tready = 1'b0;
                repeat (HoldCycles) @(negedge i_clk);
                holds_done++;
            end else if (gap_left > 0) begin
                m_axis_tready = 1'b0;
                gap_left--;
            end else begin
                m_axis_tready = 1'b1;
                gap_left = pick_gap(rx_steady);
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        hold_reqs     = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: corners, patch borders, all coordinate bits set
        send_pixel('0, '0, 8'd0, 8'd0, 8'd0);
        send_pixel(CoordW'(MaxCoord), CoordW'(MaxCoord), 8'd255, 8'd255, 8'd255);
        send_pixel(CoordW'(Patch - 1), CoordW'(Patch - 1), 8'd1, 8'd128, 8'd254);
        send_pixel(CoordW'(Patch), CoordW'(Patch), 8'h55, 8'haa, 8'h0f);
        send_pixel('1, '1, 8'haa, 8'h55, 8'hf0);

        // zero grid width, largest gain and offset
        wait_idle();
        write_reg(pna_pkg::CFG_GRID_COLUMNS, 24'hfffe00);
        write_reg(pna_pkg::CFG_NORM_SCALE, 24'hffffff);
        write_reg(pna_pkg::CFG_NORM_OFFSET, 24'h7fffff);
        send_pixel(CoordW'(MaxCoord), '0, 8'd255, 8'd0, 8'd255);
        send_pixel('0, CoordW'(MaxCoord), 8'd0, 8'd255, 8'd0);
        send_pixel('1, '1, 8'd255, 8'd255, 8'd255);

        // widest grid, zero gain, most negative offset; a write to the
        // unused index must leave the grid alone
        wait_idle();
        write_reg(pna_pkg::CFG_GRID_COLUMNS, 24'hfe01ff);
        write_reg(pna_pkg::CFG_NORM_SCALE, 24'h000000);
        write_reg(pna_pkg::CFG_NORM_OFFSET, 24'h800000);
        write_reg(CfgUnused, 24'h000003);
        send_pixel(CoordW'(MaxCoord), CoordW'(MaxCoord), 8'd255, 8'd255, 8'd255);
        send_pixel('1, '1, 8'd0, 8'd0, 8'd0);
        send_pixel(CoordW'(Patch * MaxGrid - 1), CoordW'(Patch - 1), 8'd200, 8'd100, 8'd50);

        // gain of half an output lsb: exact halves must round up
        wait_idle();
        write_reg(pna_pkg::CFG_GRID_COLUMNS, 24'd73);
        write_reg(pna_pkg::CFG_NORM_SCALE, 24'd128);
        write_reg(pna_pkg::CFG_NORM_OFFSET, 24'd0);
        send_pixel(CoordW'(27), CoordW'(41), 8'd1, 8'd2, 8'd3);
        send_pixel(CoordW'(7152), CoordW'(7000), 8'd255, 8'd1, 8'd0);

        for (int phase = 0; phase < PhaseCount; phase++) begin
            wait_idle();
            random_config();
            // phase 1 fills the block behind a long hold-off, phase 3 runs flat out
            tx_steady = (phase == 1 || phase == 3);
            rx_steady = (phase == 3);
            if (phase == 1)
                hold_reqs++;
            for (int n = 0; n < PhaseItems; n++)
                send_pixel(rand_coord(), rand_coord(), rand_level(), rand_level(),
                           rand_level());
        end

        wait_idle();
        repeat (DrainCycles) @(negedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
